/* hw/rtl/stt_pkg.sv */
// Shared types and constants for the source text tokenizer.
// Holds token kinds, lexer modes, character codes and the keyword matcher.
// No dependencies.
package stt_pkg;

	localparam int KIND_W   = 6;
	localparam int START_W  = 32;
	localparam int LEN_W    = 16;
	localparam int KW_MAX   = 6;
	localparam int RES_MAX  = 3;

	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	localparam logic [KIND_W-1:0] K_NUMBER   = 6'd0;
	localparam logic [KIND_W-1:0] K_IDENT    = 6'd1;
	localparam logic [KIND_W-1:0] K_VAR      = 6'd2;
	localparam logic [KIND_W-1:0] K_CONST    = 6'd4;
	localparam logic [KIND_W-1:0] K_COMMA    = 6'd5;
	localparam logic [KIND_W-1:0] K_COLON    = 6'd6;
	localparam logic [KIND_W-1:0] K_DOT      = 6'd7;
	localparam logic [KIND_W-1:0] K_SQUOTE   = 6'd8;
	localparam logic [KIND_W-1:0] K_DQUOTE   = 6'd9;
	localparam logic [KIND_W-1:0] K_FUNCT    = 6'd10;
	localparam logic [KIND_W-1:0] K_RETURN   = 6'd11;
	localparam logic [KIND_W-1:0] K_IF       = 6'd12;
	localparam logic [KIND_W-1:0] K_AND      = 6'd13;
	localparam logic [KIND_W-1:0] K_OR       = 6'd14;
	localparam logic [KIND_W-1:0] K_INC      = 6'd15;
	localparam logic [KIND_W-1:0] K_DEC      = 6'd16;
	localparam logic [KIND_W-1:0] K_FOR      = 6'd17;
	localparam logic [KIND_W-1:0] K_ELSE     = 6'd18;
	localparam logic [KIND_W-1:0] K_WHILE    = 6'd19;
	localparam logic [KIND_W-1:0] K_BINOP    = 6'd20;
	localparam logic [KIND_W-1:0] K_EQUALS   = 6'd21;
	localparam logic [KIND_W-1:0] K_DEQUALS  = 6'd22;
	localparam logic [KIND_W-1:0] K_GREQ     = 6'd23;
	localparam logic [KIND_W-1:0] K_LSEQ     = 6'd24;
	localparam logic [KIND_W-1:0] K_GR       = 6'd25;
	localparam logic [KIND_W-1:0] K_LS       = 6'd26;
	localparam logic [KIND_W-1:0] K_NEQ      = 6'd27;
	localparam logic [KIND_W-1:0] K_SEMI     = 6'd28;
	localparam logic [KIND_W-1:0] K_LPAREN   = 6'd29;
	localparam logic [KIND_W-1:0] K_RPAREN   = 6'd30;
	localparam logic [KIND_W-1:0] K_LBRACE   = 6'd31;
	localparam logic [KIND_W-1:0] K_RBRACE   = 6'd32;
	localparam logic [KIND_W-1:0] K_LBRACKET = 6'd33;
	localparam logic [KIND_W-1:0] K_RBRACKET = 6'd34;
	localparam logic [KIND_W-1:0] K_ENDFILE  = 6'd35;
	localparam logic [KIND_W-1:0] K_ERROR    = 6'd36;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQ     = 8'h22;
	localparam logic [7:0] CH_SQ     = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CASE_BIT  = 8'h20;

	typedef enum logic [2:0] {
		M_IDLE    = 3'd0,
		M_PEND    = 3'd1,
		M_COMMENT = 3'd2,
		M_DIGITS  = 3'd3,
		M_WORD    = 3'd4,
		M_STRING  = 3'd5
	} mode_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
	} tok_t;

	typedef struct packed {
		tok_t tok;
		logic last;
	} entry_t;

	typedef struct packed {
		logic              two;
		logic [KIND_W-1:0] kind;
	} kw_t;

	function automatic tok_t mk_tok(input logic [KIND_W-1:0] kind,
		input logic [START_W-1:0] start, input logic [LEN_W-1:0] len);
		tok_t t;
		t.kind  = kind;
		t.start = start;
		t.len   = len;
		return t;
	endfunction

	// Matches a letter run against the keywords. The first letter matches in either
	// case, as does the third letter of the combined if-else word.
	function automatic kw_t kw_match(input logic [KW_MAX-1:0][7:0] pre,
		input logic [LEN_W-1:0] len);
		kw_t r;
		logic [7:0] c0;
		logic [7:0] c2;
		c0 = pre[0] | CASE_BIT;
		c2 = pre[2] | CASE_BIT;
		r.two  = 1'b0;
		r.kind = K_IDENT;
		if (len == 16'd6 && c0 == "i" && pre[1] == "f" && c2 == "e" && pre[3] == "l"
			&& pre[4] == "s" && pre[5] == "e") begin
			r.two  = 1'b1;
			r.kind = K_IF;
		end else if (len == 16'd3 && c0 == "v" && pre[1] == "a" && pre[2] == "r") begin
			r.kind = K_VAR;
		end else if (len == 16'd2 && c0 == "i" && pre[1] == "f") begin
			r.kind = K_IF;
		end else if (len == 16'd5 && c0 == "c" && pre[1] == "o" && pre[2] == "n"
			&& pre[3] == "s" && pre[4] == "t") begin
			r.kind = K_CONST;
		end else if (len == 16'd6 && c0 == "r" && pre[1] == "e" && pre[2] == "t"
			&& pre[3] == "u" && pre[4] == "r" && pre[5] == "n") begin
			r.kind = K_RETURN;
		end else if (len == 16'd5 && c0 == "f" && pre[1] == "u" && pre[2] == "n"
			&& pre[3] == "c" && pre[4] == "t") begin
			r.kind = K_FUNCT;
		end else if (len == 16'd4 && c0 == "e" && pre[1] == "l" && pre[2] == "s"
			&& pre[3] == "e") begin
			r.kind = K_ELSE;
		end else if (len == 16'd5 && c0 == "w" && pre[1] == "h" && pre[2] == "i"
			&& pre[3] == "l" && pre[4] == "e") begin
			r.kind = K_WHILE;
		end else if (len == 16'd3 && c0 == "f" && pre[1] == "o" && pre[2] == "r") begin
			r.kind = K_FOR;
		end else if (len == 16'd2 && c0 == "o" && pre[1] == "r") begin
			r.kind = K_OR;
		end else if (len == 16'd3 && c0 == "a" && pre[1] == "n" && pre[2] == "d") begin
			r.kind = K_AND;
		end
		return r;
	endfunction

endpackage

/* hw/rtl/source_text_tokenizer_unit.sv */
// Source text tokenizer: one byte per request in, token records out.
// Depends on stt_pkg for token kinds, modes, characters and the keyword matcher.
// A request's tokens are written into the result queue and offered from its head.
// Throughput: one request per cycle while each request yields at most one token and
// out_ready is high; a request yielding up to three tokens drains through the four-entry
// result queue. Requests are taken while the queue holds at most one token.
// Reset clears the lexer state, the offset counter and the queue at once.
module source_text_tokenizer_unit #(
	parameter int OFFSET_BITS       = 32,
	parameter int WORD_PREFIX_DEPTH = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           req_type,
	input  logic [7:0]                     byte_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [stt_pkg::KIND_W-1:0]     token_kind,
	output logic [stt_pkg::START_W-1:0]    token_start,
	output logic [stt_pkg::LEN_W-1:0]      token_length,
	output logic                           last_of_run
);

	localparam int PIDX_W = $clog2(WORD_PREFIX_DEPTH);
	localparam int Q_DEPTH = 4;
	localparam int QPTR_W = $clog2(Q_DEPTH);
	localparam int QCNT_W = QPTR_W + 1;

	stt_pkg::mode_t                mode_q, mode_d;
	logic [7:0]                    pend_q, pend_d;
	logic                          qd_q, qd_d;
	logic                          empty_q, empty_d;
	logic [OFFSET_BITS-1:0]        off_q, off_d;
	logic [OFFSET_BITS-1:0]        run_start_q, run_start_d;
	logic [stt_pkg::LEN_W-1:0]     run_len_q, run_len_d;
	logic                          halted_q, halted_d;
	logic [7:0]                    prefix_q [WORD_PREFIX_DEPTH];

	stt_pkg::entry_t               fifo_q [Q_DEPTH];
	logic [QPTR_W-1:0]             wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]             count_q;

	logic                          in_fire, pop;
	logic                          pw_en;
	logic [PIDX_W-1:0]             pw_idx;
	logic [stt_pkg::LEN_W-1:0]     run_len_inc;
	logic [stt_pkg::START_W-1:0]   off32, run32;
	logic [stt_pkg::KW_MAX-1:0][7:0] pre;
	stt_pkg::kw_t                  kw;

	logic                          is_digit, is_letter, is_blank, is_quote, is_dq;
	logic                          id_emit, id_pend, id_run, id_quote, id_halt;
	logic [stt_pkg::KIND_W-1:0]    id_kind;
	stt_pkg::mode_t                id_mode;

	logic [7:0]                    want;
	logic [stt_pkg::KIND_W-1:0]    pair_kind, lone_kind;
	logic                          lone_ok;

	logic [1:0]                    fl_n;
	stt_pkg::tok_t                 fl0, fl1, tl;
	logic                          tl_v, do_idle;
	stt_pkg::tok_t                 res [stt_pkg::RES_MAX];
	logic [1:0]                    res_n;

	assign in_ready  = (count_q <= QCNT_W'(1));
	assign in_fire   = in_valid && in_ready;
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;

	assign token_kind   = fifo_q[rd_ptr_q].tok.kind;
	assign token_start  = fifo_q[rd_ptr_q].tok.start;
	assign token_length = fifo_q[rd_ptr_q].tok.len;
	assign last_of_run  = fifo_q[rd_ptr_q].last;

	assign off32       = stt_pkg::START_W'(off_q);
	assign run32       = stt_pkg::START_W'(run_start_q);
	assign run_len_inc = (run_len_q == stt_pkg::LEN_MAX) ? run_len_q : run_len_q + 16'd1;

	always_comb begin
		for (int i = 0; i < stt_pkg::KW_MAX; i++) begin
			pre[i] = prefix_q[i];
		end
	end

	assign kw = stt_pkg::kw_match(pre, run_len_q);

	assign is_digit  = (byte_value >= "0") && (byte_value <= "9");
	assign is_letter = ((byte_value >= "A") && (byte_value <= "Z"))
		|| ((byte_value >= "a") && (byte_value <= "z"));
	assign is_blank  = (byte_value == stt_pkg::CH_LF) || (byte_value == stt_pkg::CH_CR)
		|| (byte_value == stt_pkg::CH_TAB) || (byte_value == stt_pkg::CH_SPACE)
		|| (byte_value == stt_pkg::CH_NUL) || (byte_value == stt_pkg::CH_BSLASH);
	assign is_dq     = (byte_value == stt_pkg::CH_DQ);
	assign is_quote  = is_dq || (byte_value == stt_pkg::CH_SQ);

	// Decode of a byte met outside any run, string or comment.
	always_comb begin
		id_emit  = 1'b0;
		id_pend  = 1'b0;
		id_run   = 1'b0;
		id_quote = 1'b0;
		id_halt  = 1'b0;
		id_kind  = stt_pkg::K_ERROR;
		id_mode  = stt_pkg::M_IDLE;
		case (byte_value) inside
			"(": begin id_emit = 1'b1; id_kind = stt_pkg::K_LPAREN; end
			")": begin id_emit = 1'b1; id_kind = stt_pkg::K_RPAREN; end
			"{": begin id_emit = 1'b1; id_kind = stt_pkg::K_LBRACE; end
			"}": begin id_emit = 1'b1; id_kind = stt_pkg::K_RBRACE; end
			"[": begin id_emit = 1'b1; id_kind = stt_pkg::K_LBRACKET; end
			"]": begin id_emit = 1'b1; id_kind = stt_pkg::K_RBRACKET; end
			".": begin id_emit = 1'b1; id_kind = stt_pkg::K_DOT; end
			"*", "%": begin id_emit = 1'b1; id_kind = stt_pkg::K_BINOP; end
			";": begin id_emit = 1'b1; id_kind = stt_pkg::K_SEMI; end
			":": begin id_emit = 1'b1; id_kind = stt_pkg::K_COLON; end
			",": begin id_emit = 1'b1; id_kind = stt_pkg::K_COMMA; end
			"/", "&", "+", "-", "|", "=", ">", "<", "!": begin
				id_pend = 1'b1;
				id_mode = stt_pkg::M_PEND;
			end
			stt_pkg::CH_SQ, stt_pkg::CH_DQ: begin
				id_emit  = 1'b1;
				id_quote = 1'b1;
				id_kind  = is_dq ? stt_pkg::K_DQUOTE : stt_pkg::K_SQUOTE;
				id_mode  = stt_pkg::M_STRING;
			end
			default: begin
				if (is_digit) begin
					id_run  = 1'b1;
					id_mode = stt_pkg::M_DIGITS;
				end else if (is_letter) begin
					id_run  = 1'b1;
					id_mode = stt_pkg::M_WORD;
				end else if (!is_blank) begin
					id_emit = 1'b1;
					id_halt = 1'b1;
				end
			end
		endcase
	end

	// Second byte wanted after a pending operator, and the lone form of it.
	always_comb begin
		want      = pend_q;
		pair_kind = stt_pkg::K_BINOP;
		lone_ok   = 1'b1;
		lone_kind = stt_pkg::K_BINOP;
		case (pend_q) inside
			"&": begin pair_kind = stt_pkg::K_AND; lone_ok = 1'b0; end
			"|": begin pair_kind = stt_pkg::K_OR; lone_ok = 1'b0; end
			"+": pair_kind = stt_pkg::K_INC;
			"-": pair_kind = stt_pkg::K_DEC;
			"=": begin want = "="; pair_kind = stt_pkg::K_DEQUALS; lone_kind = stt_pkg::K_EQUALS; end
			">": begin want = "="; pair_kind = stt_pkg::K_GREQ; lone_kind = stt_pkg::K_GR; end
			"<": begin want = "="; pair_kind = stt_pkg::K_LSEQ; lone_kind = stt_pkg::K_LS; end
			"!": begin want = "="; pair_kind = stt_pkg::K_NEQ; lone_ok = 1'b0; end
			"/": lone_kind = stt_pkg::K_BINOP;
			default: lone_ok = 1'b0;
		endcase
	end

	always_comb begin
		mode_d      = mode_q;
		pend_d      = pend_q;
		qd_d        = qd_q;
		empty_d     = empty_q;
		off_d       = off_q;
		run_start_d = run_start_q;
		run_len_d   = run_len_q;
		halted_d    = halted_q;
		pw_en       = 1'b0;
		pw_idx      = run_len_q[PIDX_W-1:0];
		fl_n        = 2'd0;
		fl0         = '0;
		fl1         = '0;
		tl_v        = 1'b0;
		tl          = '0;
		do_idle     = 1'b0;

		if (!halted_q) begin
			if (!req_type) begin
				off_d = off_q + 1'b1;
				unique case (mode_q)
					stt_pkg::M_STRING: begin
						if (empty_q) begin
							empty_d = 1'b0;
							if (is_quote) begin
								qd_d   = is_dq;
								tl_v   = 1'b1;
								tl     = stt_pkg::mk_tok(is_dq ? stt_pkg::K_DQUOTE
									: stt_pkg::K_SQUOTE, off32, 16'd1);
								mode_d = stt_pkg::M_IDLE;
							end else begin
								run_start_d = off_q;
								run_len_d   = 16'd1;
							end
						end else if (byte_value == (qd_q ? stt_pkg::CH_DQ : stt_pkg::CH_SQ)) begin
							fl_n   = 2'd1;
							fl0    = stt_pkg::mk_tok(stt_pkg::K_IDENT, run32, run_len_q);
							tl_v   = 1'b1;
							tl     = stt_pkg::mk_tok(qd_q ? stt_pkg::K_DQUOTE
								: stt_pkg::K_SQUOTE, off32, 16'd1);
							mode_d = stt_pkg::M_IDLE;
						end else begin
							run_len_d = run_len_inc;
						end
					end
					stt_pkg::M_PEND: begin
						mode_d = stt_pkg::M_IDLE;
						if (byte_value == want) begin
							if (pend_q == "/") begin
								mode_d = stt_pkg::M_COMMENT;
							end else begin
								tl_v = 1'b1;
								tl   = stt_pkg::mk_tok(pair_kind, run32, 16'd2);
							end
						end else if (lone_ok) begin
							fl_n    = 2'd1;
							fl0     = stt_pkg::mk_tok(lone_kind, run32, 16'd1);
							do_idle = 1'b1;
						end else begin
							fl_n     = 2'd1;
							fl0      = stt_pkg::mk_tok(stt_pkg::K_ERROR, run32, 16'd1);
							halted_d = 1'b1;
						end
					end
					stt_pkg::M_COMMENT: begin
						if (byte_value == stt_pkg::CH_LF || byte_value == stt_pkg::CH_CR) begin
							mode_d = stt_pkg::M_IDLE;
						end
					end
					stt_pkg::M_DIGITS: begin
						if (is_digit) begin
							run_len_d = run_len_inc;
						end else begin
							fl_n    = 2'd1;
							fl0     = stt_pkg::mk_tok(stt_pkg::K_NUMBER, run32, run_len_q);
							do_idle = 1'b1;
						end
					end
					stt_pkg::M_WORD: begin
						if (is_letter) begin
							pw_en     = (run_len_q < 16'(WORD_PREFIX_DEPTH));
							run_len_d = run_len_inc;
						end else begin
							fl_n    = kw.two ? 2'd2 : 2'd1;
							fl0     = stt_pkg::mk_tok(kw.kind, run32, run_len_q);
							fl1     = stt_pkg::mk_tok(stt_pkg::K_ELSE, run32, run_len_q);
							do_idle = 1'b1;
						end
					end
					stt_pkg::M_IDLE: do_idle = 1'b1;
					default: do_idle = 1'b1;
				endcase

				if (do_idle) begin
					mode_d = id_mode;
					tl_v   = id_emit;
					tl     = stt_pkg::mk_tok(id_kind, off32, 16'd1);
					if (id_pend) begin
						pend_d      = byte_value;
						run_start_d = off_q;
					end
					if (id_run) begin
						run_start_d = off_q;
						run_len_d   = 16'd1;
						pw_en       = 1'b1;
						pw_idx      = '0;
					end
					if (id_quote) begin
						qd_d    = is_dq;
						empty_d = 1'b1;
					end
					if (id_halt) begin
						halted_d = 1'b1;
					end
				end
			end else begin
				if (mode_q == stt_pkg::M_STRING) begin
					if (!empty_q) begin
						fl_n = 2'd1;
						fl0  = stt_pkg::mk_tok(stt_pkg::K_IDENT, run32, run_len_q);
					end
				end else if (mode_q == stt_pkg::M_PEND) begin
					fl_n = 2'd1;
					fl0  = stt_pkg::mk_tok(lone_ok ? lone_kind : stt_pkg::K_ERROR, run32, 16'd1);
				end else if (mode_q == stt_pkg::M_DIGITS) begin
					fl_n = 2'd1;
					fl0  = stt_pkg::mk_tok(stt_pkg::K_NUMBER, run32, run_len_q);
				end else if (mode_q == stt_pkg::M_WORD) begin
					fl_n = kw.two ? 2'd2 : 2'd1;
					fl0  = stt_pkg::mk_tok(kw.kind, run32, run_len_q);
					fl1  = stt_pkg::mk_tok(stt_pkg::K_ELSE, run32, run_len_q);
				end

				if (mode_q == stt_pkg::M_PEND && !lone_ok) begin
					halted_d = 1'b1;
				end else begin
					tl_v        = 1'b1;
					tl          = stt_pkg::mk_tok(stt_pkg::K_ENDFILE, off32, 16'd0);
					mode_d      = stt_pkg::M_IDLE;
					pend_d      = '0;
					qd_d        = 1'b0;
					empty_d     = 1'b0;
					off_d       = '0;
					run_start_d = '0;
					run_len_d   = '0;
				end
			end
		end
	end

	// Packs the flushed tokens first and the token of the new byte after them.
	always_comb begin
		res[0] = fl0;
		res[1] = fl1;
		res[2] = tl;
		case (fl_n)
			2'd0: res[0] = tl;
			2'd1: res[1] = tl;
			default: res[2] = tl;
		endcase
		res_n = fl_n + {1'b0, tl_v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= stt_pkg::M_IDLE;
			pend_q      <= '0;
			qd_q        <= 1'b0;
			empty_q     <= 1'b0;
			off_q       <= '0;
			run_start_q <= '0;
			run_len_q   <= '0;
			halted_q    <= 1'b0;
		end else if (in_fire) begin
			mode_q      <= mode_d;
			pend_q      <= pend_d;
			qd_q        <= qd_d;
			empty_q     <= empty_d;
			off_q       <= off_d;
			run_start_q <= run_start_d;
			run_len_q   <= run_len_d;
			halted_q    <= halted_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && pw_en) begin
			prefix_q[pw_idx] <= byte_value;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < stt_pkg::RES_MAX; i++) begin
				if (2'(i) < res_n) begin
					fifo_q[wr_ptr_q + QPTR_W'(i)].tok  <= res[i];
					fifo_q[wr_ptr_q + QPTR_W'(i)].last <= (2'(i) == res_n - 2'd1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_fire) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(res_n);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (in_fire ? QCNT_W'(res_n) : '0) - QCNT_W'(pop);
		end
	end

endmodule
